// File: src/chga_pkg.sv
`default_nettype none

package chga_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int PART_W   = 2;
    localparam int THETA_W  = 6;
    localparam int PHI_W    = 7;
    localparam int ENERGY_W = 20;
    localparam int SUM_W    = 24;
    localparam int HITS_W   = 16;

    typedef struct packed {
        logic [PART_W-1:0]  part;
        logic [THETA_W-1:0] theta;
        logic [PHI_W-1:0]   phi;
    } key_t;

    typedef struct packed {
        key_t                key;
        logic [ENERGY_W-1:0] energy;
        logic                last;
    } hit_t;

    typedef struct packed {
        key_t              key;
        logic [SUM_W-1:0]  sum;
        logic [HITS_W-1:0] hits;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic             overflow;
        logic             reading;
    } table_status_t;

endpackage

`default_nettype wire

// File: src/crystal_hit_grouping_accumulator.sv
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------------
// hits in  | in_valid / in_ready    | part_id, theta_index, phi_index, hit_energy,
//          |                        | last_hit
// groups   | out_valid / out_ready  | out_part, out_theta, out_phi, energy_sum,
//          |                        | hit_count, table_overflowed, last_entry
//
// A hit passes the table engine in order: a lookup compares its key against all live
// keys and reads the matching entry, then an update merges or appends. A two-item
// queue in front lets new hits land while the engine is busy.
// A last hit adds a readout of every stored entry, each a memory read, then an output
// register load.
// Reset (rst_n low, asynchronous) empties the table, the queue and the output stage;
// entry memory contents are left as they are and never read before being written.
// The output register holds an item under back pressure; the engine stalls in
// readout until it frees, while the queue keeps taking hits.

module crystal_hit_grouping_accumulator
    import chga_pkg::*;
(
    input  wire  logic                 clk,
    input  wire  logic                 rst_n,
    input  wire  logic                 in_valid,
    output logic                       in_ready,
    input  wire  logic [PART_W-1:0]    part_id,
    input  wire  logic [THETA_W-1:0]   theta_index,
    input  wire  logic [PHI_W-1:0]     phi_index,
    input  wire  logic [ENERGY_W-1:0]  hit_energy,
    input  wire  logic                 last_hit,
    output logic                       out_valid,
    input  wire  logic                 out_ready,
    output logic [PART_W-1:0]          out_part,
    output logic [THETA_W-1:0]         out_theta,
    output logic [PHI_W-1:0]           out_phi,
    output logic [SUM_W-1:0]           energy_sum,
    output logic [HITS_W-1:0]          hit_count,
    output logic                       table_overflowed,
    output logic                       last_entry
);

    hit_t          in_item;
    hit_t          q_item;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    table_status_t tbl_status;

    // pack the incoming hit into one item
    assign in_item = '{key:    '{part: part_id, theta: theta_index, phi: phi_index},
                       energy: hit_energy,
                       last:   last_hit};

    assign in_ready = !q_full;

    chga_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !q_full),
        .push_item  (in_item),
        .full       (q_full),
        .pop        (q_pop),
        .item_valid (q_valid),
        .item       (q_item)
    );

    chga_table u_table
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (q_valid),
        .item             (q_item),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_part         (out_part),
        .out_theta        (out_theta),
        .out_phi          (out_phi),
        .energy_sum       (energy_sum),
        .hit_count        (hit_count),
        .table_overflowed (table_overflowed),
        .last_entry       (last_entry),
        .status           (tbl_status)
    );

    // the table never holds more entries than it has rows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_status.entry_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // a dropped key can only happen with a full table
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tbl_status.overflow) |-> $past(tbl_status.entry_count) == CNT_W'(TABLE_ENTRIES))
        else $error("overflow flagged with free rows");

    // readout never runs over an empty table
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_status.reading |-> tbl_status.entry_count != '0)
        else $error("readout with no entries");

endmodule

`default_nettype wire

// File: src/chga_queue.sv
`default_nettype none

module chga_queue
    import chga_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic push,
    input  wire  hit_t push_item,
    output logic       full,
    input  wire  logic pop,
    output logic       item_valid,
    output hit_t       item
);

    hit_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full       = (fill_reg == 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // store the item; slots carry no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/chga_table.sv
`default_nettype none

module chga_table
    import chga_pkg::*;
(
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    input  wire  logic                item_valid,
    input  wire  hit_t                item,
    output logic                      pop,
    output logic                      out_valid,
    input  wire  logic                out_ready,
    output logic [PART_W-1:0]         out_part,
    output logic [THETA_W-1:0]        out_theta,
    output logic [PHI_W-1:0]          out_phi,
    output logic [SUM_W-1:0]          energy_sum,
    output logic [HITS_W-1:0]         hit_count,
    output logic                      table_overflowed,
    output logic                      last_entry,
    output table_status_t             status
);

    typedef enum logic [3:0] {
        ST_LOOKUP = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_RDADDR = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic             overflow_reg, overflow_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    hit_t             hit_reg;
    logic             hit_match_reg;
    logic [IDX_W-1:0] hit_idx_reg;

    key_t             key_reg [TABLE_ENTRIES];
    entry_t           mem [TABLE_ENTRIES];
    entry_t           rd_data_reg;

    logic                  out_valid_reg, out_valid_next;
    entry_t                out_data_reg;
    logic                  out_ovf_reg;
    logic                  out_last_reg;

    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [IDX_W-1:0]         match_idx;
    logic                     any_match;
    logic                     table_full;
    logic                     out_free;
    logic                     emit_last;
    logic [CNT_W-1:0]         count_last;

    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             key_we;
    logic             out_load;

    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [HITS_W-1:0] hits_sat;

    // parallel compare against live entries; keys are unique so at most one hits
    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = (CNT_W'(i) < entry_count_reg) && (key_reg[i] == item.key);
            if (match_vec[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
        any_match = |match_vec;
    end

    assign table_full = (entry_count_reg == CNT_W'(TABLE_ENTRIES));
    assign out_free   = !out_valid_reg || out_ready;
    assign count_last = entry_count_reg - CNT_W'(1);
    assign emit_last  = (CNT_W'(rd_idx_reg) == count_last);

    // saturating merge of the fetched entry
    always_comb
    begin
        sum_wide = {1'b0, rd_data_reg.sum} + (SUM_W + 1)'(hit_reg.energy);
        sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        hits_sat = (&rd_data_reg.hits) ? rd_data_reg.hits : rd_data_reg.hits + HITS_W'(1);
    end

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        overflow_next    = overflow_reg;
        rd_idx_next      = rd_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pop              = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = match_idx;
        mem_we           = 1'b0;
        mem_waddr        = hit_idx_reg;
        mem_wdata        = '0;
        key_we           = 1'b0;
        out_load         = 1'b0;

        case (state_reg)
            ST_LOOKUP:
            begin
                if (item_valid)
                begin
                    pop        = 1'b1;
                    mem_re     = any_match;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (hit_match_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{key: hit_reg.key, sum: sum_sat, hits: hits_sat};
                end
                else if (!table_full)
                begin
                    mem_we           = 1'b1;
                    key_we           = 1'b1;
                    mem_waddr        = entry_count_reg[IDX_W-1:0];
                    mem_wdata        = '{key:  hit_reg.key,
                                         sum:  SUM_W'(hit_reg.energy),
                                         hits: HITS_W'(1)};
                    entry_count_next = entry_count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
                rd_idx_next = '0;
                state_next  = hit_reg.last ? ST_RDADDR : ST_LOOKUP;
            end
            ST_RDADDR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = rd_idx_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (emit_last)
                    begin
                        entry_count_next = '0;
                        overflow_next    = 1'b0;
                        state_next       = ST_LOOKUP;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_RDADDR;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOOKUP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOOKUP;
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            overflow_reg    <= overflow_next;
            rd_idx_reg      <= rd_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hit_reg       <= item;
            hit_match_reg <= any_match;
            hit_idx_reg   <= match_idx;
        end
        if (key_we)
        begin
            key_reg[mem_waddr] <= hit_reg.key;
        end
        if (out_load)
        begin
            out_data_reg <= rd_data_reg;
            out_ovf_reg  <= overflow_reg;
            out_last_reg <= emit_last;
        end
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_part         = out_data_reg.key.part;
    assign out_theta        = out_data_reg.key.theta;
    assign out_phi          = out_data_reg.key.phi;
    assign energy_sum       = out_data_reg.sum;
    assign hit_count        = out_data_reg.hits;
    assign table_overflowed = out_ovf_reg;
    assign last_entry       = out_last_reg;

    assign status = '{entry_count: entry_count_reg,
                      overflow:    overflow_reg,
                      reading:     (state_reg == ST_RDADDR) || (state_reg == ST_EMIT)};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import chga_pkg::*;

    // A correct run of a few hundred items ends well within this limit, even with
    // the heaviest idling and full-table readouts.
    localparam int CYCLE_LIMIT  = 100_000;
    // Wait past a full-table readout for stray items.
    localparam int DRAIN_CYCLES = 300;

    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
    localparam logic [HITS_W-1:0]   HITS_MAX   = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    // One grouped crystal as it should leave the block.
    typedef struct {
        entry_t entry;
        logic   overflow;
        logic   last;
    } group_t;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic [PART_W-1:0]   part_id          = '0;
    logic [THETA_W-1:0]  theta_index      = '0;
    logic [PHI_W-1:0]    phi_index        = '0;
    logic [ENERGY_W-1:0] hit_energy       = '0;
    logic                last_hit         = 1'b0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    logic [PART_W-1:0]   out_part;
    logic [THETA_W-1:0]  out_theta;
    logic [PHI_W-1:0]    out_phi;
    logic [SUM_W-1:0]    energy_sum;
    logic [HITS_W-1:0]   hit_count;
    logic                table_overflowed;
    logic                last_entry;

    // Idling odds, in percent per cycle, set by some tests.
    int idle_pct  = 0;
    int stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    // Shadow copy of the grouping table.
    entry_t tbl_entry [TABLE_ENTRIES];
    int     tbl_used     = 0;
    logic   tbl_overflow = 1'b0;

    group_t pending_groups [$];

    crystal_hit_grouping_accumulator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .part_id          (part_id),
        .theta_index      (theta_index),
        .phi_index        (phi_index),
        .hit_energy       (hit_energy),
        .last_hit         (last_hit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_part         (out_part),
        .out_theta        (out_theta),
        .out_phi          (out_phi),
        .energy_sum       (energy_sum),
        .hit_count        (hit_count),
        .table_overflowed (table_overflowed),
        .last_entry       (last_entry)
    );

    always #5 clk = ~clk;

    // Merge a hit into the shadow table: add to a matching key, else append,
    // else flag the overflow and drop the hit.
    function automatic void group_hit(key_t k, logic [ENERGY_W-1:0] e);
        int             i;
        logic [SUM_W:0] s;
        for (i = 0; i < tbl_used; i++)
        begin
            if (tbl_entry[i].key == k)
            begin
                s = {1'b0, tbl_entry[i].sum} + (SUM_W + 1)'(e);
                // Clamp the sum; bit SUM_W set means it went past the maximum.
                tbl_entry[i].sum = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
                if (tbl_entry[i].hits != HITS_MAX)
                    tbl_entry[i].hits++;
                return;
            end
        end
        if (tbl_used < TABLE_ENTRIES)
        begin
            tbl_entry[tbl_used].key  = k;
            tbl_entry[tbl_used].sum  = SUM_W'(e);
            tbl_entry[tbl_used].hits = HITS_W'(1);
            tbl_used++;
        end
        else
            tbl_overflow = 1'b1;
    endfunction

    // Queue every stored entry in insertion order, then clear the table.
    function automatic void read_out_table();
        group_t g;
        int     i;
        for (i = 0; i < tbl_used; i++)
        begin
            g.entry    = tbl_entry[i];
            g.overflow = tbl_overflow;
            g.last     = (i == tbl_used - 1);
            pending_groups.insert(pending_groups.size(), g);
        end
        tbl_used     = 0;
        tbl_overflow = 1'b0;
    endfunction

    task automatic check_field(string name, logic [31:0] expd, logic [31:0] got);
        if (got !== expd)
        begin
            $error("%s: expected %0d, got %0d", name, expd, got);
            err_count++;
        end
    endtask

    // Sample both channels at the rising edge. Predict from the accepted hit first,
    // then compare an accepted group against the oldest pending one.
    always @(posedge clk)
    begin
        group_t exp_g;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                group_hit({part_id, theta_index, phi_index}, hit_energy);
                if (last_hit)
                    read_out_table();
            end
            if (out_valid && out_ready)
            begin
                if (pending_groups.size() == 0)
                begin
                    $error("group item with none pending: part %0d theta %0d phi %0d",
                           out_part, out_theta, out_phi);
                    err_count++;
                end
                else
                begin
                    exp_g = pending_groups.pop_front();
                    check_field("out_part", exp_g.entry.key.part, out_part);
                    check_field("out_theta", exp_g.entry.key.theta, out_theta);
                    check_field("out_phi", exp_g.entry.key.phi, out_phi);
                    check_field("energy_sum", exp_g.entry.sum, energy_sum);
                    check_field("hit_count", exp_g.entry.hits, hit_count);
                    check_field("table_overflowed", exp_g.overflow, table_overflowed);
                    check_field("last_entry", exp_g.last, last_entry);
                end
            end
        end
    end

    // Receiver: drop ready at random, changed only at the falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Send one hit item. Call just after a falling edge; return just after one.
    // Hold valid across back-to-back items so it is never dropped and raised in
    // the same step.
    task automatic send_hit(key_t k, logic [ENERGY_W-1:0] e, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        part_id     <= k.part;
        theta_index <= k.theta;
        phi_index   <= k.phi;
        hit_energy  <= e;
        last_hit    <= last;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Any part value, out-of-range three included.
    function automatic key_t rand_key();
        key_t k;
        k.part  = PART_W'($urandom_range(3));
        k.theta = THETA_W'($urandom_range(63));
        k.phi   = PHI_W'($urandom_range(127));
        return k;
    endfunction

    // Bias energies toward zero and the top of the range so sums saturate now and then.
    function automatic logic [ENERGY_W-1:0] rand_energy();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ENERGY_MAX;
            2:       return ENERGY_MAX - ENERGY_W'($urandom_range(4095));
            3:       return ENERGY_W'($urandom_range(255));
            default: return ENERGY_W'($urandom());
        endcase
    endfunction

    // A lone last hit forms a one-entry event; cover both key and energy extremes.
    task automatic test_single_hit_events();
        idle_pct  = 0;
        stall_pct = 0;
        send_hit('{2'd3, 6'd63, 7'd127}, ENERGY_MAX, 1'b1);
        send_hit('{2'd0, 6'd0, 7'd0}, '0, 1'b1);
    endtask

    // Repeated keys merge, new keys append, readout follows insertion order.
    task automatic test_merge_order();
        key_t ka;
        key_t kb;
        key_t kc;
        ka = '{2'd0, 6'd0, 7'd127};
        kb = '{2'd1, 6'd63, 7'd0};
        kc = '{2'd2, 6'd32, 7'd64};
        send_hit(ka, 20'd1000, 1'b0);
        send_hit(kb, 20'd2500, 1'b0);
        send_hit(ka, 20'd7, 1'b0);
        send_hit(kc, '0, 1'b0);     // zero energy still counts as a hit
        send_hit(kb, 20'hA5A5A, 1'b1);
    endtask

    // Seventeen full-scale hits on one crystal push the sum past its maximum.
    task automatic test_energy_saturation();
        int i;
        for (i = 0; i < 17; i++)
            send_hit('{2'd1, 6'd21, 7'd85}, ENERGY_MAX, i == 16);
    endtask

    // Fill all entries, then show new keys dropped while a stored key still merges.
    // A lone hit after the readout checks that the overflow flag cleared.
    task automatic test_table_full();
        key_t k;
        int   i;
        stall_pct = 20;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            k.part  = PART_W'(i);
            k.theta = THETA_W'(i);
            k.phi   = PHI_W'(i);
            send_hit(k, rand_energy(), 1'b0);
        end
        send_hit('{2'd2, 6'd63, 7'd127}, ENERGY_MAX, 1'b0);
        send_hit('{2'd0, 6'd0, 7'd0}, ENERGY_MAX, 1'b0);
        send_hit('{2'd2, 6'd63, 7'd127}, 20'd5, 1'b0);
        send_hit('{2'd1, 6'd0, 7'd127}, 20'd9, 1'b1);
        send_hit('{2'd1, 6'd0, 7'd127}, 20'd9, 1'b1);
    endtask

    // Random events under one idling setting. Most events reuse a few keys so that
    // hits merge; some use fresh keys; a few are long enough to overflow the table.
    task automatic test_random_events(int n_items, int send_idle, int recv_stall);
        key_t pool [8];
        int   pool_n;
        int   fresh_pct;
        int   kind;
        int   len;
        int   sent;
        int   j;
        key_t k;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        sent      = 0;
        while (sent < n_items)
        begin
            for (j = 0; j < 8; j++)
                pool[j] = rand_key();
            pool_n = $urandom_range(8, 1);
            kind   = $urandom_range(99);
            if (kind < 70)
            begin
                len       = $urandom_range(16, 1);
                fresh_pct = 0;
            end
            else if (kind < 88)
            begin
                len       = $urandom_range(10, 1);
                fresh_pct = 100;
            end
            else
            begin
                len       = $urandom_range(80, 62);
                fresh_pct = 80;
            end
            for (j = 0; j < len; j++)
            begin
                if ($urandom_range(99) < fresh_pct)
                    k = rand_key();
                else
                    k = pool[$urandom_range(pool_n - 1)];
                send_hit(k, rand_energy(), j == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        // Hold reset low from the start, release it on a falling edge.
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_hit_events();
        test_merge_order();
        test_energy_saturation();
        test_table_full();
        test_random_events(82, 0, 0);
        test_random_events(82, 45, 0);
        test_random_events(82, 0, 45);
        test_random_events(82, 38, 38);

        in_valid <= 1'b0;
        // Drain: wait for every pending group, then watch for extra items.
        while (pending_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
src/chga_pkg.sv
src/chga_queue.sv
src/chga_table.sv
src/crystal_hit_grouping_accumulator.sv
tb/tb_top.sv
